>>> hdl/nnis_pkg.sv
package nnis_pkg;

   // Sizes of the source frame store and the destination grid
   localparam int MAX_SRC_DIM   = 256;
   localparam int MAX_DST_DIM   = 4096;
   localparam int PIXEL_BITS    = 32;

   // Field and register widths
   localparam int COORD_BITS    = 12;
   localparam int SRC_DIM_BITS  = 9;
   localparam int DST_DIM_BITS  = 13;
   localparam int CSR_DATA_BITS = 13;
   localparam int CSR_IDX_BITS  = 3;

   // Derived store geometry
   localparam int SRC_IDX_BITS  = $clog2(MAX_SRC_DIM);
   localparam int ADDR_BITS     = 2 * SRC_IDX_BITS;
   localparam int STORE_DEPTH   = MAX_SRC_DIM * MAX_SRC_DIM;

   // Divider: dividend is a coordinate times a source size, quotient one source index
   localparam int PROD_BITS     = COORD_BITS + SRC_DIM_BITS;
   localparam int STEP_BITS     = $clog2(SRC_IDX_BITS);

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DST_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DST_HEIGHT = 3'd3;

   // Item modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MUL    = 5'b00010,
      ST_DIV    = 5'b00100,
      ST_RDREQ  = 5'b01000,
      ST_RDWAIT = 5'b10000
   } state_type;

   // Zero counts as one, anything above the maximum counts as the maximum
   function automatic logic [SRC_DIM_BITS-1:0] clamp_src(input logic [SRC_DIM_BITS-1:0] v);
      logic [SRC_DIM_BITS-1:0] r;
      if (v == '0) begin
         r = SRC_DIM_BITS'(1);
      end else if (v > SRC_DIM_BITS'(MAX_SRC_DIM)) begin
         r = SRC_DIM_BITS'(MAX_SRC_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [DST_DIM_BITS-1:0] clamp_dst(input logic [DST_DIM_BITS-1:0] v);
      logic [DST_DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DST_DIM_BITS'(1);
      end else if (v > DST_DIM_BITS'(MAX_DST_DIM)) begin
         r = DST_DIM_BITS'(MAX_DST_DIM);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

>>> hdl/nnis_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data
module nnis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/nearest_neighbor_image_scaler.sv
// Nearest-neighbour image scaler. A write item (mode 0) stores one source pixel at
// (col,row) in a 256x256 frame store and completes in the cycle of its transfer; writes
// outside the configured source size are dropped. A read item (mode 1) clamps its
// destination coordinate to the configured destination size, maps it to the source
// pixel floor(col*src_width/dst_width), floor(row*src_height/dst_height) and returns
// that word unchanged. One item is in work at a time: a write frees the input in the
// next cycle; a read holds req_stall from the transfer until its result is loaded, and
// passes through a multiply state, a restoring divide with one divider per axis running
// in parallel, a memory read request and a wait for the read data, which then loads the
// output register; the wait stretches while an earlier result is still stalled in the
// output register. A finished result waits in the output register while the next item
// is taken. Pixels never written read back as undefined.
// Size registers may be changed only while the block is idle.
module nearest_neighbor_image_scaler (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_write_enable,
   input  logic [nnis_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [nnis_pkg::CSR_DATA_BITS-1:0]    csr_data,
   // input items
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic [nnis_pkg::COORD_BITS-1:0]       req_col,
   input  logic [nnis_pkg::COORD_BITS-1:0]       req_row,
   input  logic [nnis_pkg::PIXEL_BITS-1:0]       req_pixel_in,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [nnis_pkg::PIXEL_BITS-1:0]       rsp_pixel_out
);

   // Configuration registers
   logic [nnis_pkg::SRC_DIM_BITS-1:0] src_width_ff, src_height_ff;
   logic [nnis_pkg::DST_DIM_BITS-1:0] dst_width_ff, dst_height_ff;

   // Effective sizes
   logic [nnis_pkg::SRC_DIM_BITS-1:0] sw, sh;
   logic [nnis_pkg::DST_DIM_BITS-1:0] dw, dh;

   // Sequencer and datapath
   nnis_pkg::state_type state_ff, state_in;
   logic [nnis_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic [nnis_pkg::COORD_BITS-1:0]   col_ff, col_in, row_ff, row_in;
   logic [nnis_pkg::PROD_BITS-1:0]    rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [nnis_pkg::PROD_BITS-1:0]    dvs_x_ff, dvs_x_in, dvs_y_ff, dvs_y_in;
   logic [nnis_pkg::SRC_IDX_BITS-1:0] quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic                              ge_x, ge_y;

   // Output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [nnis_pkg::PIXEL_BITS-1:0]   rsp_pixel_ff, rsp_pixel_in;

   // Handshakes and memory ports
   logic                              req_xfer, rsp_xfer, out_free;
   logic                              wr_en, rd_en;
   logic [nnis_pkg::ADDR_BITS-1:0]    wr_addr, rd_addr;
   logic [nnis_pkg::PIXEL_BITS-1:0]   rd_data;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= nnis_pkg::SRC_DIM_BITS'(nnis_pkg::MAX_SRC_DIM);
         src_height_ff <= nnis_pkg::SRC_DIM_BITS'(nnis_pkg::MAX_SRC_DIM);
         dst_width_ff  <= nnis_pkg::DST_DIM_BITS'(256);
         dst_height_ff <= nnis_pkg::DST_DIM_BITS'(256);
      end else if (csr_write_enable) begin
         case (csr_index)
            nnis_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_data[nnis_pkg::SRC_DIM_BITS-1:0];
            nnis_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_data[nnis_pkg::SRC_DIM_BITS-1:0];
            nnis_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_data;
            nnis_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign sw = nnis_pkg::clamp_src(src_width_ff);
   assign sh = nnis_pkg::clamp_src(src_height_ff);
   assign dw = nnis_pkg::clamp_dst(dst_width_ff);
   assign dh = nnis_pkg::clamp_dst(dst_height_ff);

   assign req_stall = (state_ff != nnis_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Source pixel write straight from the transfer
   assign wr_en   = req_xfer && (req_mode == nnis_pkg::MODE_WRITE)
                    && ({1'b0, req_col} < (nnis_pkg::COORD_BITS+1)'(sw))
                    && ({1'b0, req_row} < (nnis_pkg::COORD_BITS+1)'(sh));
   assign wr_addr = {req_row[nnis_pkg::SRC_IDX_BITS-1:0], req_col[nnis_pkg::SRC_IDX_BITS-1:0]};
   assign rd_addr = {quo_y_ff, quo_x_ff};
   assign rd_en   = (state_ff == nnis_pkg::ST_RDREQ);

   // Restoring divide step, both axes
   assign ge_x = (rem_x_ff >= dvs_x_ff);
   assign ge_y = (rem_y_ff >= dvs_y_ff);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      dvs_x_in     = dvs_x_ff;
      dvs_y_in     = dvs_y_ff;
      quo_x_in     = quo_x_ff;
      quo_y_in     = quo_y_ff;
      rsp_valid_in = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_pixel_in = rsp_pixel_ff;
      case (state_ff)
         nnis_pkg::ST_IDLE: begin
            // read transfer: clamp to destination size
            if (req_xfer && (req_mode == nnis_pkg::MODE_READ)) begin
               col_in   = ({1'b0, req_col} >= dw) ? nnis_pkg::COORD_BITS'(dw - 1'b1) : req_col;
               row_in   = ({1'b0, req_row} >= dh) ? nnis_pkg::COORD_BITS'(dh - 1'b1) : req_row;
               state_in = nnis_pkg::ST_MUL;
            end
         end
         nnis_pkg::ST_MUL: begin
            // dividends and top-aligned divisors; the quotient is below the source size
            rem_x_in = nnis_pkg::PROD_BITS'(col_ff) * nnis_pkg::PROD_BITS'(sw);
            rem_y_in = nnis_pkg::PROD_BITS'(row_ff) * nnis_pkg::PROD_BITS'(sh);
            dvs_x_in = nnis_pkg::PROD_BITS'(dw) << (nnis_pkg::SRC_IDX_BITS - 1);
            dvs_y_in = nnis_pkg::PROD_BITS'(dh) << (nnis_pkg::SRC_IDX_BITS - 1);
            quo_x_in = '0;
            quo_y_in = '0;
            step_in  = '0;
            state_in = nnis_pkg::ST_DIV;
         end
         nnis_pkg::ST_DIV: begin
            rem_x_in = ge_x ? (rem_x_ff - dvs_x_ff) : rem_x_ff;
            rem_y_in = ge_y ? (rem_y_ff - dvs_y_ff) : rem_y_ff;
            dvs_x_in = dvs_x_ff >> 1;
            dvs_y_in = dvs_y_ff >> 1;
            quo_x_in = {quo_x_ff[nnis_pkg::SRC_IDX_BITS-2:0], ge_x};
            quo_y_in = {quo_y_ff[nnis_pkg::SRC_IDX_BITS-2:0], ge_y};
            step_in  = step_ff + 1'b1;
            if (step_ff == nnis_pkg::STEP_BITS'(nnis_pkg::SRC_IDX_BITS - 1)) begin
               state_in = nnis_pkg::ST_RDREQ;
            end
         end
         nnis_pkg::ST_RDREQ: begin
            state_in = nnis_pkg::ST_RDWAIT;
         end
         nnis_pkg::ST_RDWAIT: begin
            // read data holds until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = rd_data;
               state_in     = nnis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = nnis_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nnis_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      rem_x_ff     <= rem_x_in;
      rem_y_ff     <= rem_y_in;
      dvs_x_ff     <= dvs_x_in;
      dvs_y_ff     <= dvs_y_in;
      quo_x_ff     <= quo_x_in;
      quo_y_ff     <= quo_y_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   // Frame store
   nnis_ram #(
      .WIDTH (nnis_pkg::PIXEL_BITS),
      .DEPTH (nnis_pkg::STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

endmodule

>>> hdl/nnis_checker.sv
module nnis_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_mode,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [nnis_pkg::PIXEL_BITS-1:0]   rsp_pixel_out
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out))
      else $error("stalled result changed or dropped");

   // A write transfer leaves the input free
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == nnis_pkg::MODE_WRITE) |=> !req_stall)
      else $error("input stalled after a write transfer");

   // A read transfer occupies the block
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == nnis_pkg::MODE_READ) |=> req_stall)
      else $error("input free right after a read transfer");

   // No result appears the cycle after a read transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == nnis_pkg::MODE_READ) |=> !$rose(rsp_valid))
      else $error("result too early");

   // A new result only comes at the end of a busy period
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a read in work");

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_nnis_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_mode      (req_mode),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out)
);
